>>> sv/assert_macros.svh
// Assertion macros shared by the dimmer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BDC_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("dimmer assertion failed");

// Next-cycle implication, checked while out of reset.
`define BDC_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("dimmer assertion failed");

`endif

>>> sv/bdc_pkg.sv
// Shared types, constants and functions of the button dimmer.
package bdc_pkg;

    localparam int HOLD_BITS = 11;
    localparam int LONG_BITS = 11;
    localparam int DEB_BITS  = 8;
    localparam int CMP_BITS  = (HOLD_BITS > LONG_BITS) ? HOLD_BITS : LONG_BITS;
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 2'd1;

    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET   = 8'd15;
    localparam logic [LONG_BITS-1:0] LONG_PRESS_RESET = 11'd1000;

    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_SET_LEVEL = 2'd1;
    localparam logic [1:0] MODE_SET_ON    = 2'd2;

    localparam logic [6:0] LEVEL_MAX      = 7'd100;
    localparam logic [6:0] LEVEL_STEP     = 7'd10;
    localparam logic [6:0] LEVEL_UP_LIMIT = 7'd90;
    localparam logic [6:0] LEVEL_SEG1_END = 7'd25;
    localparam logic [6:0] LEVEL_SEG2_END = 7'd50;
    localparam logic [6:0] LEVEL_FULL     = 7'd98;

    localparam logic [11:0] DUTY_DARK = 12'd4095;
    localparam logic [11:0] DUTY_SEG1 = 12'd4040;
    localparam logic [11:0] DUTY_SEG2 = 12'd4020;
    localparam logic [11:0] DUTY_SEG3 = 12'd4000;
    localparam logic [11:0] DUTY_FULL = 12'd0;

    typedef struct packed {
        logic [1:0] mode;
        logic       up_button_low;
        logic       down_button_low;
        logic       power_button_low;
        logic       link_connected;
        logic [7:0] set_value;
    } bdc_in_t;

    typedef struct packed {
        logic [11:0] pwm_duty;
        logic [6:0]  level_now;
        logic        lamp_on;
        logic        settings_changed;
        logic        factory_reset;
    } bdc_out_t;

    // Per-button status at the current tick.
    typedef struct packed {
        logic release_now;   // button sampled released
        logic debounced;     // held >= debounce_ticks
        logic short_enough;  // held <= long_press_ticks
        logic long_enough;   // held >= long_press_ticks
    } btn_stat_t;

    // Round down to a multiple of ten (level stays within 0..100).
    function automatic logic [6:0] floor_tens(input logic [6:0] lv);
        logic [6:0] r;
        r = 7'd0;
        for (int i = 1; i <= 10; i++) begin
            if (lv >= 7'(i * 10)) begin
                r = 7'(i * 10);
            end
        end
        return r;
    endfunction

    // Inverted duty: dark when off or at level 0, three linear segments, full above 98.
    function automatic logic [11:0] duty_of(input logic [6:0] lv, input logic on);
        logic [6:0]  x;
        logic [7:0]  t5;
        logic [13:0] p;
        logic [7:0]  t3;
        logic [1:0]  q;
        logic [11:0] d;
        x  = 7'd0;
        t5 = 8'd0;
        p  = 14'd0;
        t3 = 8'd0;
        q  = 2'd0;
        if (!on || lv == 7'd0) begin
            d = DUTY_DARK;
        end else if (lv <= LEVEL_SEG1_END) begin
            // (x*20)/24 == (5x)/6, 5x <= 120; 43/256 reciprocal is exact there
            x  = lv - 7'd1;
            t5 = 8'(x) * 8'd5;
            p  = 14'(t5) * 14'd43;
            d  = DUTY_SEG1 - 12'(p[13:8]);
        end else if (lv <= LEVEL_SEG2_END) begin
            x  = lv - 7'd26;
            t5 = 8'(x) * 8'd5;
            p  = 14'(t5) * 14'd43;
            d  = DUTY_SEG2 - 12'(p[13:8]);
        end else if (lv <= LEVEL_FULL) begin
            // (x*50)/47 == x + (3x)/47, 3x <= 141
            x  = lv - 7'd51;
            t3 = 8'(x) * 8'd3;
            if (t3 >= 8'd141) begin
                q = 2'd3;
            end else if (t3 >= 8'd94) begin
                q = 2'd2;
            end else if (t3 >= 8'd47) begin
                q = 2'd1;
            end else begin
                q = 2'd0;
            end
            d = DUTY_SEG3 - 12'(x) - 12'(q);
        end else begin
            d = DUTY_FULL;
        end
        return d;
    endfunction

endpackage

>>> sv/button_dimmer_controller.sv
// Top level of the button dimmer: request and result registers, config registers.
//
// Lamp dimmer for three active-low buttons plus a remote set path. Each request on
// the s_ channel gives exactly one result on the m_ channel, in order. A request
// is first held in an input register; once the output register is free it passes
// through the button counters and the level logic and its result lands in the
// output register, where it is offered on m_valid. One request is taken every
// cycle while results keep draining: s_ready stays high whenever the input
// register is empty or moves on, and that move needs only a free output register
// (empty, or being taken this cycle through m_ready). The rate is set by the
// update of the level, on state and press counters as each request moves on.
// Configuration writes (index 0 debounce ticks, index 1 long-press ticks) are
// always taken and should only be issued with the block idle; writes to other
// indexes are dropped. After reset: level 0, lamp on, debounce 15 ticks, long
// press 1000 ticks.
`include "assert_macros.svh"

module button_dimmer_controller
    import bdc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // request channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  bdc_in_t                 s_data,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output bdc_out_t                m_data,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LONG_BITS-1:0]    cfg_data
);

    bdc_in_t              in_reg;
    logic                 in_vld_reg;
    bdc_out_t             out_reg;
    logic                 out_vld_reg;
    logic [DEB_BITS-1:0]  debounce_reg;
    logic [LONG_BITS-1:0] long_press_reg;

    logic      advance;
    logic      tick;
    btn_stat_t up_stat;
    btn_stat_t down_stat;
    btn_stat_t power_stat;
    bdc_out_t  result;

    // Advance the held request when the output register is free or draining.
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign tick      = advance && (in_reg.mode == MODE_TICK);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    // Input register: hold the request until the level logic consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Output register: capture the result, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEB_BITS-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default: begin
                    debounce_reg <= debounce_reg;
                end
            endcase
        end
    end

    bdc_button u_up (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (tick),
        .button_low       (in_reg.up_button_low),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .stat             (up_stat)
    );

    bdc_button u_down (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (tick),
        .button_low       (in_reg.down_button_low),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .stat             (down_stat)
    );

    bdc_button u_power (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick             (tick),
        .button_low       (in_reg.power_button_low),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .stat             (power_stat)
    );

    bdc_level u_level (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (in_reg),
        .up_stat    (up_stat),
        .down_stat  (down_stat),
        .power_stat (power_stat),
        .result     (result)
    );

    // A consumed request always leaves a result in the output register.
    `BDC_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_vld_reg)
    // A blocked request stays in the input register.
    `BDC_ASSERT_NEXT(a_blocked_holds, aclk, aresetn, in_vld_reg && !advance, in_vld_reg)
    // A dark lamp always drives the dark duty code.
    `BDC_ASSERT_NOW(a_off_is_dark, aclk, aresetn, out_vld_reg && !out_reg.lamp_on,
        out_reg.pwm_duty == DUTY_DARK)
    // Level never leaves its range.
    `BDC_ASSERT_NOW(a_level_range, aclk, aresetn, out_vld_reg,
        out_reg.level_now <= LEVEL_MAX)

endmodule

>>> sv/bdc_button.sv
// Press counter and release classification for one active-low button.
module bdc_button
    import bdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  logic                 button_low,
    input  logic [DEB_BITS-1:0]  debounce_ticks,
    input  logic [LONG_BITS-1:0] long_press_ticks,
    output btn_stat_t            stat
);

    logic [HOLD_BITS-1:0] held_reg;
    logic [HOLD_BITS-1:0] held_next;
    logic [CMP_BITS-1:0]  held_ext;

    assign held_ext = CMP_BITS'(held_reg);

    always_comb begin
        held_next = held_reg;
        if (tick) begin
            if (!button_low) begin
                held_next = (held_reg != HOLD_MAX) ? held_reg + 1'b1 : held_reg;
            end else begin
                held_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    assign stat.release_now  = button_low;
    assign stat.debounced    = held_ext >= CMP_BITS'(debounce_ticks);
    assign stat.short_enough = held_ext <= CMP_BITS'(long_press_ticks);
    assign stat.long_enough  = held_ext >= CMP_BITS'(long_press_ticks);

endmodule

>>> sv/bdc_level.sv
// Level and on-state registers with button actions, set requests and duty.
module bdc_level
    import bdc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  bdc_in_t   item,
    input  btn_stat_t up_stat,
    input  btn_stat_t down_stat,
    input  btn_stat_t power_stat,
    output bdc_out_t  result
);

    logic [6:0] level_reg;
    logic [6:0] level_next;
    logic       on_reg;
    logic       on_next;
    logic [6:0] level_up;
    logic [6:0] up_floor;
    logic [6:0] down_floor;
    logic       up_act;
    logic       down_act;
    logic       toggle;
    logic       freset;
    logic       changed;

    assign up_act   = up_stat.release_now && up_stat.debounced;
    assign down_act = down_stat.release_now && down_stat.debounced;
    assign toggle   = power_stat.release_now && power_stat.debounced
                      && power_stat.short_enough;

    // Up is applied first, down works on its result.
    assign up_floor   = floor_tens(level_reg);
    assign down_floor = floor_tens(level_up);

    always_comb begin
        if (!up_act) begin
            level_up = level_reg;
        end else if (level_reg <= LEVEL_UP_LIMIT) begin
            level_up = up_floor + LEVEL_STEP;
        end else begin
            level_up = LEVEL_MAX;
        end
    end

    always_comb begin
        level_next = level_reg;
        on_next    = on_reg;
        changed    = 1'b0;
        freset     = 1'b0;
        case (item.mode)
            MODE_TICK: begin
                if (down_act) begin
                    level_next = (level_up >= LEVEL_STEP) ? down_floor - LEVEL_STEP : 7'd0;
                end else begin
                    level_next = level_up;
                end
                if (toggle) begin
                    on_next = !on_reg;
                end
                freset  = power_stat.release_now && !toggle && power_stat.long_enough
                          && !item.link_connected;
                changed = up_act || down_act || toggle;
            end
            MODE_SET_LEVEL: begin
                level_next = (item.set_value > 8'(LEVEL_MAX)) ? LEVEL_MAX
                                                              : item.set_value[6:0];
                changed    = 1'b1;
            end
            MODE_SET_ON: begin
                on_next = item.set_value[0];
                changed = 1'b1;
            end
            default: begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 7'd0;
            on_reg    <= 1'b1;
        end else if (advance) begin
            level_reg <= level_next;
            on_reg    <= on_next;
        end
    end

    assign result.pwm_duty         = duty_of(level_next, on_next);
    assign result.level_now        = level_next;
    assign result.lamp_on          = on_next;
    assign result.settings_changed = changed;
    assign result.factory_reset    = freset;

endmodule
